### hw/rtl/refcounted_attach_table_assert.svh
// assertion macros used by the checker in rat_checker.sv
`ifndef REFCOUNTED_ATTACH_TABLE_ASSERT_SVH
`define REFCOUNTED_ATTACH_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, held off during reset
`define RAT_ASSERT_IMPLIES(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("refcounted_attach_table: assertion failed");

// next-cycle implication
`define RAT_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("refcounted_attach_table: assertion failed");

// delayed implication
`define RAT_ASSERT_AFTER3(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##3 (b)) \
        else $error("refcounted_attach_table: assertion failed");

`endif

### hw/rtl/rat_pkg.sv
// types, constants and state codes of the reference-counted attach table
package rat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int REF_BITS    = 16;
    localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KEY_BITS    = 31;
    localparam int ADDR_BITS   = 64;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ATTACH = 2'd1;
    localparam logic [1:0] ACT_DETACH = 2'd2;

    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    typedef struct packed {
        logic [1:0]           action;
        logic [KEY_BITS-1:0]  segment_id;
        logic [ADDR_BITS-1:0] attach_address;
    } rat_req_t;

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] address;
        logic                 released;
        logic                 table_full;
    } rat_resp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_RESP
    } rat_state_t;

    typedef struct packed {
        logic load;
        logic match_en;
        logic update_en;
    } rat_cmd_t;

endpackage

### hw/rtl/refcounted_attach_table.sv
// top level of the reference-counted attach table
//
//   channel   ports                       handshake
//   -------   -------------------------   ------------------------------
//   in        start, busy, request        taken when start && !busy
//   out       done, result                one-cycle strobe, always taken
//
// from acceptance to its result strobe, a word passes a registered
// parallel key and free-entry search, then one read-modify-write of the entry
// a new word is taken in the cycle its predecessor's result is shown, so
// back-to-back words skip the idle state; no new word is taken while busy
// reset clears the state machine and all valid bits at once; no clearing pass
// the receiver cannot stall: each result is strobed by done for exactly one cycle
module refcounted_attach_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rat_pkg::rat_req_t  request,
    output logic               done,
    output rat_pkg::rat_resp_t result
);

    rat_pkg::rat_cmd_t cmd;

    rat_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rat_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

endmodule

### hw/rtl/rat_datapath.sv
// table storage, parallel key match and entry update
module rat_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rat_pkg::rat_cmd_t cmd,
    input  rat_pkg::rat_req_t request,
    output rat_pkg::rat_resp_t result
);

    rat_pkg::rat_req_t  req_reg;
    rat_pkg::rat_resp_t resp_reg;
    rat_pkg::rat_resp_t resp_next;

    logic [rat_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [rat_pkg::KEY_BITS-1:0]    key_reg  [rat_pkg::TABLE_DEPTH];
    logic [rat_pkg::ADDR_BITS-1:0]   base_reg [rat_pkg::TABLE_DEPTH];
    logic [rat_pkg::REF_BITS-1:0]    refs_reg [rat_pkg::TABLE_DEPTH];

    logic                          hit_next, hit_reg;
    logic                          free_next, free_reg;
    logic [rat_pkg::IDX_BITS-1:0]  hit_idx_next, hit_idx_reg;
    logic [rat_pkg::IDX_BITS-1:0]  free_idx_next, free_idx_reg;

    logic [rat_pkg::ADDR_BITS-1:0] base_cur;
    logic [rat_pkg::REF_BITS-1:0]  refs_cur;

    // write controls for the update step
    logic                          wr_new;
    logic                          wr_refs;
    logic                          wr_clear;
    logic [rat_pkg::REF_BITS-1:0]  refs_new;

    // lowest index wins on both searches
    always_comb
    begin
        hit_next      = 1'b0;
        free_next     = 1'b0;
        hit_idx_next  = '0;
        free_idx_next = '0;
        for (int i = rat_pkg::TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == req_reg.segment_id))
            begin
                hit_next     = 1'b1;
                hit_idx_next = rat_pkg::IDX_BITS'(i);
            end
            if (!valid_reg[i])
            begin
                free_next     = 1'b1;
                free_idx_next = rat_pkg::IDX_BITS'(i);
            end
        end
    end

    assign base_cur = base_reg[hit_idx_reg];
    assign refs_cur = refs_reg[hit_idx_reg];

    always_comb
    begin
        resp_next = '0;
        wr_new    = 1'b0;
        wr_refs   = 1'b0;
        wr_clear  = 1'b0;
        refs_new  = refs_cur;
        case (req_reg.action)
            rat_pkg::ACT_LOOKUP:
            begin
                resp_next.found = hit_reg;
                if (hit_reg)
                begin
                    resp_next.address = base_cur;
                end
            end
            rat_pkg::ACT_ATTACH:
            begin
                if (hit_reg)
                begin
                    resp_next.found = 1'b1;
                    // count saturates
                    if (refs_cur != rat_pkg::REF_MAX)
                    begin
                        wr_refs  = 1'b1;
                        refs_new = refs_cur + rat_pkg::REF_ONE;
                    end
                end
                else if (free_reg)
                begin
                    wr_new = 1'b1;
                end
                else
                begin
                    resp_next.table_full = 1'b1;
                end
            end
            rat_pkg::ACT_DETACH:
            begin
                if (!hit_reg)
                begin
                    resp_next.released = 1'b1;
                end
                else
                begin
                    resp_next.found = 1'b1;
                    if (refs_cur <= rat_pkg::REF_ONE)
                    begin
                        wr_clear           = 1'b1;
                        resp_next.released = 1'b1;
                    end
                    else
                    begin
                        wr_refs  = 1'b1;
                        refs_new = refs_cur - rat_pkg::REF_ONE;
                    end
                end
            end
            default:
            begin
                resp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.update_en)
        begin
            if (wr_new)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            else if (wr_clear)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.match_en)
        begin
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
        end
        if (cmd.update_en)
        begin
            resp_reg <= resp_next;
            if (wr_new)
            begin
                key_reg[free_idx_reg]  <= req_reg.segment_id;
                base_reg[free_idx_reg] <= req_reg.attach_address;
                refs_reg[free_idx_reg] <= rat_pkg::REF_ONE;
            end
            else if (wr_refs)
            begin
                refs_reg[hit_idx_reg] <= refs_new;
            end
        end
    end

    assign result = resp_reg;

endmodule

### hw/rtl/rat_controller.sv
// sequencer: accept, match, update, respond
module rat_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output rat_pkg::rat_cmd_t cmd
);

    rat_pkg::rat_state_t state_reg;
    rat_pkg::rat_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rat_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rat_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rat_pkg::ST_MATCH;
                end
            end
            rat_pkg::ST_MATCH:
            begin
                state_next = rat_pkg::ST_UPDATE;
            end
            rat_pkg::ST_UPDATE:
            begin
                state_next = rat_pkg::ST_RESP;
            end
            rat_pkg::ST_RESP:
            begin
                // a new word may be taken while the result is shown
                state_next = start ? rat_pkg::ST_MATCH : rat_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy         = 1'b0;
        done         = 1'b0;
        cmd          = '0;
        case (state_reg)
            rat_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            rat_pkg::ST_MATCH:
            begin
                busy         = 1'b1;
                cmd.match_en = 1'b1;
            end
            rat_pkg::ST_UPDATE:
            begin
                busy          = 1'b1;
                cmd.update_en = 1'b1;
            end
            rat_pkg::ST_RESP:
            begin
                done     = 1'b1;
                cmd.load = start;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/rat_checker.sv
// port-level checks of the attach table, bound to the top level
`include "refcounted_attach_table_assert.svh"

module rat_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input rat_pkg::rat_resp_t result
);

    logic others_zero;
    logic lookup_hit;

    // a refused attach carries nothing but the full flag
    assign others_zero = !result.found && !result.released && (result.address == '0);
    assign lookup_hit  = result.found && !result.released;

    `RAT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    `RAT_ASSERT_AFTER3(a_result_after_accept, start && !busy, done)
    `RAT_ASSERT_IMPLIES(a_not_busy_on_result, done, !busy)
    `RAT_ASSERT_IMPLIES(a_full_alone, done && result.table_full, others_zero)
    `RAT_ASSERT_IMPLIES(a_address_needs_hit, done && (result.address != '0), lookup_hit)

endmodule

bind refcounted_attach_table rat_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
